// ===== design/tcg_pkg.sv =====
package tcg_pkg;

    localparam int unsigned TICKS_PER_SECOND = 1000;
    localparam int unsigned MS_W = (TICKS_PER_SECOND > 1) ? $clog2(TICKS_PER_SECOND) : 1;
    localparam logic [MS_W-1:0] MS_LAST = MS_W'(TICKS_PER_SECOND - 1);

    localparam int unsigned TEMP_W = 15;
    localparam int unsigned TARGET_W = 14;
    localparam int unsigned BAND_W = 10;
    localparam int unsigned SEC_W = 16;
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic signed [TARGET_W-1:0] TARGET_MIN = -14'sd2000;
    localparam logic signed [TARGET_W-1:0] TARGET_MAX = 14'sd5000;
    localparam logic signed [TARGET_W-1:0] TARGET_RESET = 14'sd2000;
    localparam logic [BAND_W-1:0] BAND_MIN = 10'd10;
    localparam logic [BAND_W-1:0] BAND_MAX = 10'd1000;
    localparam logic [BAND_W-1:0] BAND_RESET = 10'd50;
    localparam logic [SEC_W-1:0] GUARD_RESET = 16'd60;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_TARGET = 2'd0,
        CFG_BAND   = 2'd1,
        CFG_GUARD  = 2'd2
    } cfg_index_t;

    typedef enum logic [2:0] {
        MODE_IDLE = 3'd0,
        MODE_WAIT = 3'd1,
        MODE_COOL = 3'd2,
        MODE_HEAT = 3'd3,
        MODE_ERR  = 3'd4
    } mode_t;

    typedef enum logic {
        FUNC_TICK   = 1'b0,
        FUNC_SAMPLE = 1'b1
    } func_t;

    typedef struct packed {
        logic signed [TARGET_W-1:0] target;
        logic [BAND_W-1:0]          band;
        logic [SEC_W-1:0]           guard;
    } cfg_t;

    typedef struct packed {
        logic                     func;
        logic signed [TEMP_W-1:0] temperature;
        logic                     sensor_ok;
        logic                     reading_valid;
    } item_t;

    typedef struct packed {
        mode_t             mode;
        logic [SEC_W-1:0]  sec;
        logic [MS_W-1:0]   ms;
    } ctrl_state_t;

    typedef struct packed {
        mode_t            mode;
        logic             cool_drive;
        logic             heat_drive;
        logic [SEC_W-1:0] delay_left_seconds;
    } result_t;

endpackage

// ===== design/tcg_step.sv =====
module tcg_step
    import tcg_pkg::*;
(
    input  cfg_t        cfg,
    input  item_t       item,
    input  ctrl_state_t state_cur,
    output ctrl_state_t state_next,
    output result_t     result
);

    logic signed [TEMP_W:0] temp_ext;
    logic signed [TEMP_W:0] target_ext;
    logic signed [TEMP_W:0] cool_at;
    logic signed [TEMP_W:0] heat_at;
    logic                   allowed;
    mode_t                  mode_sel;
    ctrl_state_t            upd;

    always_comb begin
        temp_ext   = {item.temperature[TEMP_W-1], item.temperature};
        target_ext = (TEMP_W+1)'(cfg.target);
        cool_at    = target_ext + $signed({{(TEMP_W+1-BAND_W){1'b0}}, cfg.band});
        heat_at    = target_ext - $signed({{(TEMP_W+1-BAND_W){1'b0}}, cfg.band});
        allowed    = state_cur.sec >= cfg.guard;

        mode_sel = state_cur.mode;
        case (state_cur.mode)
            MODE_WAIT: begin
                if (temp_ext <= target_ext) begin
                    mode_sel = MODE_IDLE;
                end else if (allowed) begin
                    mode_sel = MODE_COOL;
                end
            end
            MODE_COOL: begin
                if (temp_ext <= target_ext) begin
                    mode_sel = MODE_IDLE;
                end
            end
            MODE_HEAT: begin
                if (temp_ext >= target_ext) begin
                    mode_sel = MODE_IDLE;
                end
            end
            default: begin
                if (temp_ext >= cool_at) begin
                    mode_sel = allowed ? MODE_COOL : MODE_WAIT;
                end else if (temp_ext <= heat_at) begin
                    mode_sel = MODE_HEAT;
                end else begin
                    mode_sel = MODE_IDLE;
                end
            end
        endcase
        if (!item.sensor_ok || !item.reading_valid) begin
            mode_sel = MODE_ERR;
        end

        upd = state_cur;
        if (item.func == FUNC_TICK) begin
            if (!allowed) begin
                if (state_cur.ms == MS_LAST) begin
                    upd.ms  = '0;
                    upd.sec = state_cur.sec + 1'b1;
                end else begin
                    upd.ms = state_cur.ms + 1'b1;
                end
            end
        end else if (mode_sel != state_cur.mode) begin
            if (state_cur.mode == MODE_COOL) begin
                upd.sec = '0;
                upd.ms  = '0;
            end
            upd.mode = mode_sel;
        end
        state_next = upd;

        result.mode       = upd.mode;
        result.cool_drive = upd.mode == MODE_COOL;
        result.heat_drive = upd.mode == MODE_HEAT;
        result.delay_left_seconds = (upd.sec < cfg.guard) ? (cfg.guard - upd.sec) : '0;
    end

endmodule

// ===== design/thermostat_compressor_guard.sv =====
// Thermostat with compressor short-cycle protection.
// Each transfer on the s_ channel is either a one-millisecond tick (s_func low)
// or a temperature sample (s_func high), and each one yields exactly one
// transfer on the m_ channel with the mode, both relay drives and the time
// left before the compressor may start, in whole seconds rounded up.
// An item passes an input register and then one step of logic into the
// result register. One item is taken every cycle while s_ready is high;
// the mode and the elapsed-time counter are updated in that single step,
// so back-to-back items see each other's effect.
// The elapsed time is kept as seconds plus milliseconds, which yields the
// delay by one subtraction against the guard time.
// When the receiver stalls, the result register holds and s_ready falls
// only once the input register is also full.
// Configuration writes on the cfg_ channel are always accepted, take effect
// on the next cycle; setpoint and band writes are clamped to legal ranges.
// Reset sets the mode to idle, clears the elapsed time (cooling is then held
// off for the full guard time) and loads the default setpoint, band and guard.
module thermostat_compressor_guard
    import tcg_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_func,
    input  logic signed [TEMP_W-1:0]   s_temperature,
    input  logic                       s_sensor_ok,
    input  logic                       s_reading_valid,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [2:0]                 m_mode,
    output logic                       m_cool_drive,
    output logic                       m_heat_drive,
    output logic [SEC_W-1:0]           m_delay_left_seconds,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_INDEX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_wdata
);

    cfg_t        cfg_reg, cfg_next;
    item_t       item_reg;
    logic        in_valid_reg;
    ctrl_state_t state_reg, state_next;
    result_t     result_reg, result_step;
    logic        out_valid_reg;
    logic        advance;
    logic signed [TARGET_W-1:0] target_wr;
    logic [BAND_W-1:0]          band_wr;

    assign advance   = !out_valid_reg || m_ready;
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_comb begin
        target_wr = $signed(cfg_wdata[TARGET_W-1:0]);
        band_wr   = cfg_wdata[BAND_W-1:0];
        cfg_next  = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_TARGET: begin
                    if (target_wr < TARGET_MIN) begin
                        cfg_next.target = TARGET_MIN;
                    end else if (target_wr > TARGET_MAX) begin
                        cfg_next.target = TARGET_MAX;
                    end else begin
                        cfg_next.target = target_wr;
                    end
                end
                CFG_BAND: begin
                    if (band_wr < BAND_MIN) begin
                        cfg_next.band = BAND_MIN;
                    end else if (band_wr > BAND_MAX) begin
                        cfg_next.band = BAND_MAX;
                    end else begin
                        cfg_next.band = band_wr;
                    end
                end
                CFG_GUARD: begin
                    cfg_next.guard = cfg_wdata[SEC_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    tcg_step u_step (
        .cfg        (cfg_reg),
        .item       (item_reg),
        .state_cur  (state_reg),
        .state_next (state_next),
        .result     (result_step)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.target <= TARGET_RESET;
            cfg_reg.band   <= BAND_RESET;
            cfg_reg.guard  <= GUARD_RESET;
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            state_reg.mode <= MODE_IDLE;
            state_reg.sec  <= '0;
            state_reg.ms   <= '0;
        end else begin
            cfg_reg <= cfg_next;
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
                if (in_valid_reg) begin
                    state_reg <= state_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            item_reg.func          <= s_func;
            item_reg.temperature   <= s_temperature;
            item_reg.sensor_ok     <= s_sensor_ok;
            item_reg.reading_valid <= s_reading_valid;
        end
        if (advance && in_valid_reg) begin
            result_reg <= result_step;
        end
    end

    assign m_valid              = out_valid_reg;
    assign m_mode               = result_reg.mode;
    assign m_cool_drive         = result_reg.cool_drive;
    assign m_heat_drive         = result_reg.heat_drive;
    assign m_delay_left_seconds = result_reg.delay_left_seconds;

    a_ms_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.ms <= MS_LAST)
        else $error("millisecond count out of range");

    a_out_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(in_valid_reg))
        else $error("result without an item in the input register");

    a_drive_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_cool_drive == (m_mode == MODE_COOL))
                    && (m_heat_drive == (m_mode == MODE_HEAT)))
        else $error("relay drive disagrees with mode");

endmodule

// ===== verif/testbench.sv =====
module testbench;
    import tcg_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic                     s_func = 1'b0;
    logic signed [TEMP_W-1:0] s_temperature = '0;
    logic                     s_sensor_ok = 1'b0;
    logic                     s_reading_valid = 1'b0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic [2:0]               m_mode;
    logic                     m_cool_drive;
    logic                     m_heat_drive;
    logic [SEC_W-1:0]         m_delay_left_seconds;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_INDEX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]    cfg_wdata = '0;

    thermostat_compressor_guard uut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_func               (s_func),
        .s_temperature        (s_temperature),
        .s_sensor_ok          (s_sensor_ok),
        .s_reading_valid      (s_reading_valid),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_mode               (m_mode),
        .m_cool_drive         (m_cool_drive),
        .m_heat_drive         (m_heat_drive),
        .m_delay_left_seconds (m_delay_left_seconds),
        .cfg_valid            (cfg_valid),
        .cfg_ready            (cfg_ready),
        .cfg_index            (cfg_index),
        .cfg_wdata            (cfg_wdata)
    );

    always #10 aclk = ~aclk;

    mode_t       ctl_mode;
    int unsigned since_stop_ms;
    int          set_target;
    int          set_band;
    int unsigned set_guard;

    item_t       pending_items[$];
    result_t     expected_results[$];
    item_t       next_item;
    result_t     want;
    int          burst_left = 0;
    int          gap_left = 0;
    logic [4:0]  stall_pos = '0;
    logic [31:0] ready_bits = '1;
    int          error_count = 0;

    function automatic void thermo_reset();
        ctl_mode = MODE_IDLE;
        since_stop_ms = 0;
        set_target = TARGET_RESET;
        set_band = BAND_RESET;
        set_guard = GUARD_RESET;
    endfunction

    function automatic void thermo_config(logic [CFG_INDEX_W-1:0] idx,
                                          logic [CFG_DATA_W-1:0] data);
        int v;
        case (idx)
            CFG_TARGET: begin
                v = $signed(data[TARGET_W-1:0]);
                if (v < int'(TARGET_MIN)) v = TARGET_MIN;
                if (v > int'(TARGET_MAX)) v = TARGET_MAX;
                set_target = v;
            end
            CFG_BAND: begin
                v = data[BAND_W-1:0];
                if (v < int'(BAND_MIN)) v = BAND_MIN;
                if (v > int'(BAND_MAX)) v = BAND_MAX;
                set_band = v;
            end
            CFG_GUARD: begin
                set_guard = data[SEC_W-1:0];
            end
            default: ;
        endcase
    endfunction

    function automatic result_t thermo_step(item_t it);
        mode_t       nxt;
        result_t     r;
        int unsigned limit;
        int          t;
        nxt = ctl_mode;
        limit = set_guard * TICKS_PER_SECOND;
        t = $signed(it.temperature);
        if (it.func == FUNC_TICK) begin
            if (since_stop_ms < limit) since_stop_ms++;
        end else if (!it.sensor_ok || !it.reading_valid) begin
            nxt = MODE_ERR;
        end else begin
            case (ctl_mode)
                MODE_WAIT: begin
                    if (t <= set_target) nxt = MODE_IDLE;
                    else if (since_stop_ms >= limit) nxt = MODE_COOL;
                end
                MODE_COOL: begin
                    if (t <= set_target) nxt = MODE_IDLE;
                end
                MODE_HEAT: begin
                    if (t >= set_target) nxt = MODE_IDLE;
                end
                default: begin
                    if (t >= set_target + set_band)
                        nxt = (since_stop_ms >= limit) ? MODE_COOL : MODE_WAIT;
                    else if (t <= set_target - set_band)
                        nxt = MODE_HEAT;
                    else
                        nxt = MODE_IDLE;
                end
            endcase
        end
        if (nxt != ctl_mode && ctl_mode == MODE_COOL) since_stop_ms = 0;
        ctl_mode = nxt;
        r.mode = ctl_mode;
        r.cool_drive = (ctl_mode == MODE_COOL);
        r.heat_drive = (ctl_mode == MODE_HEAT);
        r.delay_left_seconds = '0;
        if (since_stop_ms < limit)
            r.delay_left_seconds = SEC_W'((limit - since_stop_ms + TICKS_PER_SECOND - 1)
                                          / TICKS_PER_SECOND);
        return r;
    endfunction

    task automatic report_error(input string msg);
        $display("%0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic push_sample(input logic signed [TEMP_W-1:0] temp, input logic ok,
                               input logic valid_reading);
        pending_items.push_back('{func: FUNC_SAMPLE, temperature: temp,
                                  sensor_ok: ok, reading_valid: valid_reading});
    endtask

    task automatic push_ticks(input int n);
        for (int i = 0; i < n; i++)
            pending_items.push_back('{func: FUNC_TICK, temperature: TEMP_W'($urandom),
                                      sensor_ok: 1'($urandom),
                                      reading_valid: 1'($urandom)});
    endtask

    function automatic logic signed [TEMP_W-1:0] pick_temperature();
        int v;
        case ($urandom_range(0, 9))
            0: v = int'($urandom_range(0, 32767)) - 16384;
            1: v = set_target;
            2: v = set_target + set_band;
            3: v = set_target - set_band;
            4: v = set_target + set_band - 1;
            5: v = set_target - set_band + 1;
            6: v = ($urandom_range(0, 1) != 0) ? set_target + 1 : set_target - 1;
            default: v = set_target + int'($urandom_range(0, 4 * set_band)) - 2 * set_band;
        endcase
        return TEMP_W'(v);
    endfunction

    task automatic add_random_items(input int n, input int run_len);
        int         pushed = 0;
        int         r;
        int         len;
        bit         run_done;
        logic [1:0] flags;
        run_done = (run_len == 0);
        while (pushed < n) begin
            r = $urandom_range(0, 99);
            if (!run_done && pushed >= n / 2) begin
                push_ticks(run_len);
                run_done = 1'b1;
            end else if (r < 6) begin
                flags = 2'($urandom_range(0, 2));
                push_sample(TEMP_W'($urandom), flags[1], flags[0]);
                pushed++;
            end else if (r < 50) begin
                push_sample(pick_temperature(), 1'b1, 1'b1);
                pushed++;
            end else begin
                len = $urandom_range(1, 20);
                push_ticks(len);
                pushed += len;
            end
        end
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        do @(posedge aclk); while (!cfg_ready);
        thermo_config(idx, data);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        do @(negedge aclk);
        while (pending_items.size() != 0 || s_valid || expected_results.size() != 0);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                expected_results.push_back(thermo_step({s_func, s_temperature,
                                                        s_sensor_ok, s_reading_valid}));
            if (!s_valid || s_ready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (pending_items.size() != 0) begin
                    next_item = pending_items.pop_front();
                    s_valid <= 1'b1;
                    s_func <= next_item.func;
                    s_temperature <= next_item.temperature;
                    s_sensor_ok <= next_item.sensor_ok;
                    s_reading_valid <= next_item.reading_valid;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else if ($urandom_range(0, 7) == 0) begin
                        burst_left = $urandom_range(50, 200);
                        gap_left = 0;
                    end else begin
                        burst_left = $urandom_range(1, 12);
                        gap_left = $urandom_range(0, 6);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report_error("result transfer with no result expected");
                end else begin
                    want = expected_results.pop_front();
                    if (m_mode !== want.mode)
                        report_error($sformatf("mode %0d, expected %0d", m_mode, want.mode));
                    if (m_cool_drive !== want.cool_drive)
                        report_error($sformatf("cool_drive %0b, expected %0b",
                                               m_cool_drive, want.cool_drive));
                    if (m_heat_drive !== want.heat_drive)
                        report_error($sformatf("heat_drive %0b, expected %0b",
                                               m_heat_drive, want.heat_drive));
                    if (m_delay_left_seconds !== want.delay_left_seconds)
                        report_error($sformatf("delay_left_seconds %0d, expected %0d",
                                               m_delay_left_seconds, want.delay_left_seconds));
                end
            end
            if (stall_pos == 0) begin
                case ($urandom_range(0, 3))
                    0: ready_bits = '1;
                    1: ready_bits = $urandom | $urandom;
                    2: ready_bits = $urandom;
                    default: ready_bits = $urandom & $urandom;
                endcase
            end
            m_ready <= ready_bits[stall_pos];
            stall_pos++;
        end
    end

    initial begin
        #10_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        int v;
        thermo_reset();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        push_ticks(1);
        push_sample(2050, 1'b1, 1'b1);
        push_sample(2001, 1'b1, 1'b1);
        push_sample(2000, 1'b1, 1'b1);
        push_sample(1950, 1'b1, 1'b1);
        push_sample(1999, 1'b1, 1'b1);
        push_sample(2000, 1'b1, 1'b1);
        push_sample(2049, 1'b1, 1'b1);
        push_sample(1951, 1'b1, 1'b1);
        push_sample(16383, 1'b0, 1'b1);
        push_sample(-16384, 1'b1, 1'b0);
        push_sample(2049, 1'b1, 1'b1);
        push_sample(-16384, 1'b1, 1'b1);
        push_sample(16383, 1'b1, 1'b1);
        push_sample(16383, 1'b1, 1'b1);
        push_sample(2000, 1'b0, 1'b0);
        push_ticks(3);
        wait_drained();

        write_reg(CFG_TARGET, 16'h2000);
        write_reg(CFG_BAND, 16'h0000);
        write_reg(CFG_GUARD, 16'h0000);
        push_sample(-1990, 1'b1, 1'b1);
        push_ticks(2);
        push_sample(-1995, 1'b1, 1'b1);
        push_sample(-2000, 1'b1, 1'b1);
        push_sample(-1989, 1'b1, 1'b1);
        push_sample(0, 1'b1, 1'b0);
        push_sample(-2010, 1'b1, 1'b1);
        add_random_items(100, 0);
        wait_drained();

        write_reg(CFG_TARGET, 16'h1FFF);
        write_reg(CFG_BAND, 16'hFFFF);
        write_reg(CFG_GUARD, 16'd1);
        add_random_items(60, 1000);
        wait_drained();

        v = int'($urandom_range(0, 7000)) - 2000;
        write_reg(CFG_TARGET, CFG_DATA_W'(v));
        write_reg(CFG_BAND, CFG_DATA_W'($urandom_range(10, 1000)));
        write_reg(CFG_GUARD, 16'd2);
        add_random_items(40, 0);
        wait_drained();

        write_reg(CFG_GUARD, 16'd1);
        write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
        add_random_items(40, 0);
        wait_drained();

        write_reg(CFG_TARGET, CFG_DATA_W'($urandom));
        write_reg(CFG_BAND, CFG_DATA_W'($urandom));
        write_reg(CFG_GUARD, 16'hFFFF);
        add_random_items(40, 0);
        wait_drained();

        repeat (8) @(posedge aclk);
        if (expected_results.size() != 0)
            report_error($sformatf("%0d results never arrived", expected_results.size()));
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
